// ===== design/lps_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lps_pkg;

   localparam int TIME_WIDTH_DEFAULT = 32;
   localparam int NOW_W   = 32;
   localparam int HOLD_W  = 10;
   localparam int IDX_W   = 4;
   localparam int RGB_W   = 24;
   localparam int CHAN_W  = 8;
   localparam int NUM_W   = CHAN_W + HOLD_W;
   localparam int DCNT_W  = $clog2(NUM_W + 1);

   typedef enum logic [2:0] {
      PAT_BASE    = 3'd0,
      PAT_WIFI    = 3'd1,
      PAT_MQTT    = 3'd2,
      PAT_HEAT    = 3'd3,
      PAT_LAMP    = 3'd4,
      PAT_ALARM   = 3'd5,
      PAT_NONE    = 3'd7
   } pattern_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MUL_A,
      ST_MUL_B,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_PUSH
   } state_type;

   typedef struct packed {
      logic [RGB_W-1:0]  rgb;
      logic [HOLD_W-1:0] hold;
      logic              fade;
   } step_type;

   localparam logic [RGB_W-1:0] C_OFF   = 24'h000000;
   localparam logic [RGB_W-1:0] C_RED   = 24'hFF0000;
   localparam logic [RGB_W-1:0] C_GREEN = 24'h00FF00;
   localparam logic [RGB_W-1:0] C_BLUE  = 24'h0000FF;

   function automatic step_type mk_step(logic [RGB_W-1:0] rgb, int hold, logic fade);
      step_type s;
      s.rgb  = rgb;
      s.hold = HOLD_W'(hold);
      s.fade = fade;
      return s;
   endfunction

   function automatic logic [IDX_W-1:0] pattern_len(pattern_type pat);
      logic [IDX_W-1:0] len;
      case (pat)
         PAT_BASE:   len = IDX_W'(6);
         PAT_WIFI:   len = IDX_W'(3);
         PAT_MQTT:   len = IDX_W'(5);
         PAT_HEAT:   len = IDX_W'(4);
         PAT_LAMP:   len = IDX_W'(6);
         PAT_ALARM:  len = IDX_W'(12);
         default:    len = IDX_W'(1);
      endcase
      return len;
   endfunction

   function automatic step_type step_rom(pattern_type pat, logic [IDX_W-1:0] idx);
      step_type s;
      s = mk_step(C_OFF, 0, 1'b0);
      case (pat)
         PAT_BASE: begin
            case (idx)
               4'd0:    s = mk_step(C_OFF,   10,   1'b0);
               4'd1:    s = mk_step(C_RED,   1000, 1'b1);
               4'd2:    s = mk_step(C_GREEN, 1000, 1'b1);
               4'd3:    s = mk_step(C_BLUE,  1000, 1'b1);
               4'd4:    s = mk_step(C_OFF,   1000, 1'b1);
               4'd5:    s = mk_step(C_OFF,   200,  1'b0);
               default: s = mk_step(C_OFF,   0,    1'b0);
            endcase
         end
         PAT_WIFI: begin
            case (idx)
               4'd0:    s = mk_step(C_RED,   200, 1'b0);
               4'd1:    s = mk_step(C_GREEN, 200, 1'b0);
               4'd2:    s = mk_step(C_OFF,   500, 1'b0);
               default: s = mk_step(C_OFF,   0,   1'b0);
            endcase
         end
         PAT_MQTT: begin
            case (idx)
               4'd0:    s = mk_step(C_RED,   10,  1'b0);
               4'd1:    s = mk_step(C_GREEN, 500, 1'b1);
               4'd2:    s = mk_step(C_OFF,   500, 1'b1);
               4'd3:    s = mk_step(C_BLUE,  500, 1'b1);
               4'd4:    s = mk_step(C_OFF,   500, 1'b1);
               default: s = mk_step(C_OFF,   0,   1'b0);
            endcase
         end
         PAT_HEAT: begin
            case (idx)
               4'd0:    s = mk_step(C_RED,   500, 1'b0);
               4'd1:    s = mk_step(C_GREEN, 500, 1'b0);
               4'd2:    s = mk_step(C_BLUE,  500, 1'b0);
               4'd3:    s = mk_step(C_OFF,   700, 1'b0);
               default: s = mk_step(C_OFF,   0,   1'b0);
            endcase
         end
         PAT_LAMP: begin
            case (idx)
               4'd0:    s = mk_step(C_RED,   300, 1'b0);
               4'd1:    s = mk_step(C_OFF,   200, 1'b0);
               4'd2:    s = mk_step(C_GREEN, 300, 1'b0);
               4'd3:    s = mk_step(C_OFF,   200, 1'b0);
               4'd4:    s = mk_step(C_BLUE,  300, 1'b0);
               4'd5:    s = mk_step(C_OFF,   200, 1'b0);
               default: s = mk_step(C_OFF,   0,   1'b0);
            endcase
         end
         PAT_ALARM: begin
            case (idx)
               4'd0:    s = mk_step(C_RED,   100, 1'b0);
               4'd1:    s = mk_step(C_OFF,   50,  1'b0);
               4'd2:    s = mk_step(C_RED,   100, 1'b0);
               4'd3:    s = mk_step(C_OFF,   50,  1'b0);
               4'd4:    s = mk_step(C_GREEN, 100, 1'b0);
               4'd5:    s = mk_step(C_OFF,   50,  1'b0);
               4'd6:    s = mk_step(C_GREEN, 100, 1'b0);
               4'd7:    s = mk_step(C_OFF,   50,  1'b0);
               4'd8:    s = mk_step(C_BLUE,  100, 1'b0);
               4'd9:    s = mk_step(C_OFF,   50,  1'b0);
               4'd10:   s = mk_step(C_BLUE,  100, 1'b0);
               4'd11:   s = mk_step(C_OFF,   350, 1'b0);
               default: s = mk_step(C_OFF,   0,   1'b0);
            endcase
         end
         default: s = mk_step(C_OFF, 0, 1'b0);
      endcase
      return s;
   endfunction

   function automatic pattern_type choose_pattern(logic light, logic fan, logic broker,
                                                  logic wireless);
      pattern_type p;
      if (light && fan) begin
         p = PAT_ALARM;
      end else if (light) begin
         p = PAT_LAMP;
      end else if (fan) begin
         p = PAT_HEAT;
      end else if (!broker && wireless) begin
         p = PAT_MQTT;
      end else if (!wireless) begin
         p = PAT_WIFI;
      end else begin
         p = PAT_BASE;
      end
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== design/lps_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface lps_req_if;
   logic                      valid;
   logic                      ready;
   logic [lps_pkg::NOW_W-1:0] now_ms;
   logic                      light_relay_on;
   logic                      fan_on;
   logic                      broker_link_up;
   logic                      wireless_link_up;

   modport source (output valid, output now_ms, output light_relay_on, output fan_on,
                   output broker_link_up, output wireless_link_up, input ready);
   modport sink   (input valid, input now_ms, input light_relay_on, input fan_on,
                   input broker_link_up, input wireless_link_up, output ready);
endinterface

interface lps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [lps_pkg::CHAN_W-1:0] red;
   logic [lps_pkg::CHAN_W-1:0] green;
   logic [lps_pkg::CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface
`default_nettype wire

// ===== design/lps_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module lps_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [lps_pkg::NUM_W-1:0]   numer,
   input  wire logic [lps_pkg::HOLD_W-1:0]  denom,
   output logic                             done,
   output logic [lps_pkg::CHAN_W-1:0]       quotient
);
   localparam int NW = lps_pkg::NUM_W;
   localparam int DW = lps_pkg::HOLD_W;
   localparam int CW = lps_pkg::DCNT_W;

   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW+1:0] diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[NW-1]};
      diff    = {1'b0, trial} - {2'b00, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CW'(1);
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[lps_pkg::CHAN_W-1:0];
endmodule
`default_nettype wire

// ===== design/led_pattern_sequencer_fade.sv =====
// Response path: a request that gives an immediate color goes through EVAL and PUSH before
//   its response is registered; a fade request also runs MUL_A, MUL_B and the serial divider
//   for each of the 3 color channels. Throughput: one request at a time; ready drops from
//   acceptance until the sequencer is back in idle, including while PUSH waits for a stalled
//   response, with the shared 18-step divider run once per color channel for a fade.
// Reset: synchronous, active high; no pattern selected, step 0, start time and fade
//   origin cleared, response channel empty.
`timescale 1ns / 1ps
`default_nettype none
module led_pattern_sequencer_fade #(
   parameter int TIME_WIDTH = lps_pkg::TIME_WIDTH_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lps_req_if.sink    req_ch,
   lps_rsp_if.source  rsp_ch
);
   localparam int IW = lps_pkg::IDX_W;
   localparam int HW = lps_pkg::HOLD_W;
   localparam int CH = lps_pkg::CHAN_W;
   localparam int NW = lps_pkg::NUM_W;

   // Sequencer state
   lps_pkg::state_type      state_ff, state_in;
   lps_pkg::pattern_type    active_ff, active_in;
   logic [IW-1:0]           step_idx_ff, step_idx_in;
   logic [TIME_WIDTH-1:0]   start_ff, start_in;
   logic [lps_pkg::RGB_W-1:0] origin_ff, origin_in;

   // Captured request
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   lps_pkg::pattern_type    want_ff, want_in;

   // Fade datapath
   logic [HW-1:0]           elapsed_ff, elapsed_in;
   logic [HW-1:0]           hold_ff, hold_in;
   logic [lps_pkg::RGB_W-1:0] target_ff, target_in;
   logic [NW-1:0]           prod_ff, prod_in;
   logic [1:0]              chan_ff, chan_in;
   logic [lps_pkg::RGB_W-1:0] result_ff, result_in;

   // Response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [lps_pkg::RGB_W-1:0] rsp_rgb_ff, rsp_rgb_in;

   // Combinational helpers
   lps_pkg::step_type       cur_step, next_step, first_step;
   logic [IW-1:0]           pat_len, idx_next;
   logic [TIME_WIDTH-1:0]   elapsed, hold_ext;
   logic [CH-1:0]           from_byte, to_byte;
   logic                    div_start, div_done;
   logic [CH-1:0]           div_quo;

   always_comb begin
      pat_len    = lps_pkg::pattern_len(active_ff);
      cur_step   = lps_pkg::step_rom(active_ff, step_idx_ff);
      idx_next   = (step_idx_ff + IW'(1) == pat_len) ? '0 : step_idx_ff + IW'(1);
      next_step  = lps_pkg::step_rom(active_ff, idx_next);
      first_step = lps_pkg::step_rom(want_ff, '0);
      elapsed    = now_ff - start_ff;
      hold_ext   = TIME_WIDTH'(cur_step.hold);
      case (chan_ff)
         2'd0: begin
            from_byte = origin_ff[23:16];
            to_byte   = target_ff[23:16];
         end
         2'd1: begin
            from_byte = origin_ff[15:8];
            to_byte   = target_ff[15:8];
         end
         default: begin
            from_byte = origin_ff[7:0];
            to_byte   = target_ff[7:0];
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      step_idx_in  = step_idx_ff;
      start_in     = start_ff;
      origin_in    = origin_ff;
      now_in       = now_ff;
      want_in      = want_ff;
      elapsed_in   = elapsed_ff;
      hold_in      = hold_ff;
      target_in    = target_ff;
      prod_in      = prod_ff;
      chan_in      = chan_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_rgb_in   = rsp_rgb_ff;
      div_start    = 1'b0;
      req_ch.ready = 1'b0;

      case (state_ff)
         lps_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               now_in   = TIME_WIDTH'(req_ch.now_ms);
               want_in  = lps_pkg::choose_pattern(req_ch.light_relay_on, req_ch.fan_on,
                                                  req_ch.broker_link_up,
                                                  req_ch.wireless_link_up);
               state_in = lps_pkg::ST_EVAL;
            end
         end
         lps_pkg::ST_EVAL: begin
            if (want_ff != active_ff) begin
               // pattern change: snap to step 0
               active_in   = want_ff;
               step_idx_in = '0;
               start_in    = now_ff;
               origin_in   = first_step.rgb;
               result_in   = first_step.rgb;
               state_in    = lps_pkg::ST_PUSH;
            end else if (elapsed < hold_ext) begin
               if (cur_step.fade) begin
                  elapsed_in = elapsed[HW-1:0];
                  hold_in    = cur_step.hold;
                  target_in  = cur_step.rgb;
                  chan_in    = 2'd0;
                  state_in   = lps_pkg::ST_MUL_A;
               end else begin
                  state_in = lps_pkg::ST_IDLE;
               end
            end else begin
               // hold reached: advance cyclically
               origin_in   = cur_step.rgb;
               step_idx_in = idx_next;
               start_in    = now_ff;
               result_in   = next_step.rgb;
               state_in    = next_step.fade ? lps_pkg::ST_IDLE : lps_pkg::ST_PUSH;
            end
         end
         lps_pkg::ST_MUL_A: begin
            prod_in  = NW'(from_byte) * NW'(hold_ff - elapsed_ff);
            state_in = lps_pkg::ST_MUL_B;
         end
         lps_pkg::ST_MUL_B: begin
            prod_in  = prod_ff + NW'(to_byte) * NW'(elapsed_ff);
            state_in = lps_pkg::ST_DIV_START;
         end
         lps_pkg::ST_DIV_START: begin
            div_start = 1'b1;
            state_in  = lps_pkg::ST_DIV_WAIT;
         end
         lps_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               case (chan_ff)
                  2'd0:    result_in[23:16] = div_quo;
                  2'd1:    result_in[15:8]  = div_quo;
                  default: result_in[7:0]   = div_quo;
               endcase
               if (chan_ff == 2'd2) begin
                  state_in = lps_pkg::ST_PUSH;
               end else begin
                  chan_in  = chan_ff + 2'd1;
                  state_in = lps_pkg::ST_MUL_A;
               end
            end
         end
         lps_pkg::ST_PUSH: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_rgb_in   = result_ff;
               state_in     = lps_pkg::ST_IDLE;
            end
         end
         default: state_in = lps_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lps_pkg::ST_IDLE;
         active_ff    <= lps_pkg::PAT_NONE;
         step_idx_ff  <= '0;
         start_ff     <= '0;
         origin_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         step_idx_ff  <= step_idx_in;
         start_ff     <= start_in;
         origin_ff    <= origin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff     <= now_in;
      want_ff    <= want_in;
      elapsed_ff <= elapsed_in;
      hold_ff    <= hold_in;
      target_ff  <= target_in;
      prod_ff    <= prod_in;
      chan_ff    <= chan_in;
      result_ff  <= result_in;
      rsp_rgb_ff <= rsp_rgb_in;
   end

   lps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (prod_ff),
      .denom    (hold_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.red   = rsp_rgb_ff[23:16];
   assign rsp_ch.green = rsp_rgb_ff[15:8];
   assign rsp_ch.blue  = rsp_rgb_ff[7:0];
endmodule
`default_nettype wire

// ===== design/lps_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lps_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [lps_pkg::CHAN_W-1:0] rsp_red,
   input wire logic [lps_pkg::CHAN_W-1:0] rsp_green,
   input wire logic [lps_pkg::CHAN_W-1:0] rsp_blue
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
      else $error("response payload changed while stalled");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle and empty after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");
endmodule

bind led_pattern_sequencer_fade lps_checker u_lps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_red   (rsp_ch.red),
   .rsp_green (rsp_ch.green),
   .rsp_blue  (rsp_ch.blue)
);
`default_nettype wire
